/* design/hmad_pkg.sv */
// ----------------------------------------------------------------------------
// hmad_pkg
// Shared types, field widths and point helpers for the hull distance block.
// ----------------------------------------------------------------------------
package hmad_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int SQ_W      = 36;
  localparam int HALF_W    = 21;
  localparam int HSIZE_W   = 7;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 64;
  localparam int RAD_W     = 2 * HALF_W;   // radicand width, even
  localparam int REM_W     = HALF_W + 3;

  // y in the upper half, x in the lower half
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  function automatic logic pt_less(input point_t a, input point_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

  function automatic logic signed [DIFF_W-1:0] diff17(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  function automatic logic [CROSS_W-1:0] abs_cross(input logic signed [CROSS_W-1:0] v);
    logic signed [CROSS_W-1:0] n;
    n = -v;
    return v[CROSS_W-1] ? n : v;
  endfunction

endpackage

/* design/hull_min_antipodal_distance_top.sv */
// ----------------------------------------------------------------------------
// hull_min_antipodal_distance_top
// Convex hull of a point set and least antipodal vertex distance.
// ----------------------------------------------------------------------------
// Points arrive one per input transaction and are taken at one per cycle while
// the block is idle; up to MAX_POINTS are held, later ones are dropped. The
// transaction with in_tlast set closes the set: the points are insertion
// sorted by x then y in the point RAM, the monotone chain builds the hull in
// the hull RAM (strict turns only, collinear points dropped), rotating
// calipers find the least squared distance over antipodal pairs, and a
// bit-serial square root gives half the distance with four fraction bits.
// One result transaction follows; hulls of fewer than 3 vertices report zero
// distances. While a run is in progress in_tready is low. Run length is set
// by the single read port of each RAM and the one shared 17x17 multiplier;
// the sort takes O(n^2) element shifts in the worst case.
// A finished result waits in the output register; new points load meanwhile.
// ----------------------------------------------------------------------------
module hull_min_antipodal_distance_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hmad_pkg::IN_DATA_W-1:0]    in_tdata,   // point_x[15:0], point_y[31:16]
  input  logic                              in_tlast,   // last_point
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hmad_pkg::OUT_DATA_W-1:0]   out_tdata   // min_sq_distance[35:0],
                                                        // half_distance[56:36],
                                                        // hull_size[63:57]
);
  import hmad_pkg::*;

  localparam int PCW = $clog2(MAX_POINTS + 1);      // point counts
  localparam int PAW = $clog2(MAX_POINTS);          // point RAM address
  localparam int HDEPTH = 2 * MAX_POINTS;
  localparam int HAW = $clog2(HDEPTH);              // hull RAM address and counts
  localparam int SQC_W = $clog2(HALF_W + 1);

  typedef enum logic [5:0] {
    ST_IDLE, ST_S_I, ST_S_V, ST_S_J, ST_S_C,
    ST_H_I, ST_H_P, ST_H_CHK, ST_H_A, ST_H_B, ST_H_RES, ST_H_PUSH,
    ST_F0, ST_F1, ST_F2,
    ST_C_KCHK, ST_C_K1, ST_C_K2, ST_C_K3, ST_C_ICHK, ST_C_D1, ST_C_D2,
    ST_C_W0, ST_C_W1, ST_C_WCHK, ST_C_W2, ST_C_W3, ST_C_W4,
    ST_AR1, ST_AR2, ST_AR3, ST_AR4, ST_AR5,
    ST_X0, ST_X1, ST_X2, ST_X3,
    ST_SQ, ST_OUT
  } state_t;

  state_t state_r, xret_r, aret_r;

  logic [PCW-1:0] cnt_r, n_r, si_r, sj_r, hi_r;
  logic           upper_r;
  logic [HAW-1:0] k_r, t_r, kk_r, ci_r, cj_r, c1_r, c2_r;
  point_t         sv_r, pa_r, pb_r, pc_r;
  logic           dist_r, gt_r;

  logic signed [DIFF_W-1:0]  op_a_r, op_b_r, t_a_r, t_b_r;
  logic signed [PROD_W-1:0]  prod_r, acc_r;
  logic signed [CROSS_W-1:0] cr_r;
  logic [CROSS_W-1:0]        a1_r;
  logic [SQ_W-1:0]           best_r;

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [HALF_W-1:0] root_r;
  logic [SQC_W-1:0]  sqc_r;

  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;

  // RAM ports
  logic           p_we, h_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [HAW-1:0] h_waddr, h_raddr;
  point_t         p_wdata, p_rdata, h_wdata, h_rdata;

  // derived
  logic           in_acc, full, out_load;
  logic [PCW-1:0] next_n;
  logic [HAW-1:0] c_in, c_jn, m_fin;
  logic [CROSS_W-1:0]        cr_abs;
  logic [CROSS_W-1:0]        dsum;
  logic [REM_W-1:0]          rem_sh, trial;
  logic                      hull_chk;
  point_t                    in_pt;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign full       = (cnt_r == PCW'(MAX_POINTS));
  assign next_n     = full ? cnt_r : cnt_r + PCW'(1);
  assign in_pt      = in_tdata;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  // result register free or emptied at this edge
  assign out_load   = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  assign c_in   = ((ci_r + HAW'(1)) == k_r) ? '0 : ci_r + HAW'(1);
  assign c_jn   = ((cj_r + HAW'(1)) == k_r) ? '0 : cj_r + HAW'(1);
  assign m_fin  = (pa_r == h_rdata) ? k_r - HAW'(1) : k_r;
  assign cr_abs = abs_cross(cr_r);
  assign dsum   = {1'b0, acc_r} + {1'b0, prod_r};
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign hull_chk = upper_r ? (k_r > t_r) : (k_r >= HAW'(2));

  hmad_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  hmad_ram #(.WIDTH($bits(point_t)), .DEPTH(HDEPTH)) u_hull_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  // RAM address and write control
  always_comb begin
    p_we    = 1'b0;
    p_waddr = sj_r[PAW-1:0];
    p_wdata = sv_r;
    p_raddr = '0;
    h_we    = 1'b0;
    h_waddr = k_r;
    h_wdata = pc_r;
    h_raddr = '0;
    case (state_r)
      ST_IDLE: begin
        p_we    = in_acc && !full;
        p_waddr = cnt_r[PAW-1:0];
        p_wdata = in_pt;
      end
      ST_S_I:    p_raddr = si_r[PAW-1:0];
      ST_S_J: begin
        if (sj_r == '0) begin
          p_we = 1'b1;
        end else begin
          p_raddr = PAW'(sj_r - PCW'(1));
        end
      end
      ST_S_C: begin
        p_we = 1'b1;
        if (pt_less(sv_r, p_rdata)) begin
          p_wdata = p_rdata;
        end
      end
      ST_H_I:    p_raddr = upper_r ? PAW'(hi_r - PCW'(1)) : hi_r[PAW-1:0];
      ST_H_CHK:  h_raddr = k_r - HAW'(2);
      ST_H_A:    h_raddr = k_r - HAW'(1);
      ST_H_PUSH: h_we = 1'b1;
      ST_F0:     h_raddr = '0;
      ST_F1:     h_raddr = HAW'(1);
      ST_C_KCHK: h_raddr = k_r - HAW'(1);
      ST_C_K1:   h_raddr = '0;
      ST_AR1:    h_raddr = c1_r;
      ST_AR3:    h_raddr = c2_r;
      ST_C_ICHK: h_raddr = ci_r;
      ST_C_D1:   h_raddr = cj_r;
      ST_C_W0:   h_raddr = c_in;
      ST_C_W2:   h_raddr = c_jn;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // shared multiplier, one product per cycle
      prod_r <= op_a_r * op_b_r;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (!full) begin
              cnt_r <= cnt_r + PCW'(1);
            end
            if (in_tlast) begin
              n_r  <= next_n;
              si_r <= PCW'(1);
              if (next_n == PCW'(1)) begin
                k_r     <= HAW'(1);
                best_r  <= '0;
                root_r  <= '0;
                state_r <= ST_OUT;
              end else begin
                state_r <= ST_S_I;
              end
            end
          end
        end
        // insertion sort
        ST_S_I: begin
          if (si_r == n_r) begin
            hi_r    <= '0;
            k_r     <= '0;
            upper_r <= 1'b0;
            state_r <= ST_H_I;
          end else begin
            state_r <= ST_S_V;
          end
        end
        ST_S_V: begin
          sv_r    <= p_rdata;
          sj_r    <= si_r;
          state_r <= ST_S_J;
        end
        ST_S_J: begin
          if (sj_r == '0) begin
            si_r    <= si_r + PCW'(1);
            state_r <= ST_S_I;
          end else begin
            state_r <= ST_S_C;
          end
        end
        ST_S_C: begin
          if (pt_less(sv_r, p_rdata)) begin
            sj_r    <= sj_r - PCW'(1);
            state_r <= ST_S_J;
          end else begin
            si_r    <= si_r + PCW'(1);
            state_r <= ST_S_I;
          end
        end
        // monotone chain, lower then upper pass
        ST_H_I: begin
          if (!upper_r && hi_r == n_r) begin
            upper_r <= 1'b1;
            t_r     <= k_r;
            hi_r    <= n_r - PCW'(1);
          end else if (upper_r && hi_r == '0) begin
            k_r     <= k_r - HAW'(1);
            state_r <= ST_F0;
          end else begin
            state_r <= ST_H_P;
          end
        end
        ST_H_P: begin
          pc_r    <= p_rdata;
          state_r <= ST_H_CHK;
        end
        ST_H_CHK: state_r <= hull_chk ? ST_H_A : ST_H_PUSH;
        ST_H_A: begin
          pa_r    <= h_rdata;
          state_r <= ST_H_B;
        end
        ST_H_B: begin
          pb_r    <= h_rdata;
          dist_r  <= 1'b0;
          xret_r  <= ST_H_RES;
          state_r <= ST_X0;
        end
        ST_H_RES: begin
          if (!cr_r[CROSS_W-1]) begin
            k_r     <= k_r - HAW'(1);
            state_r <= ST_H_CHK;
          end else begin
            state_r <= ST_H_PUSH;
          end
        end
        ST_H_PUSH: begin
          k_r     <= k_r + HAW'(1);
          hi_r    <= upper_r ? hi_r - PCW'(1) : hi_r + PCW'(1);
          state_r <= ST_H_I;
        end
        // drop a repeated first vertex
        ST_F0: state_r <= ST_F1;
        ST_F1: begin
          pa_r    <= h_rdata;
          state_r <= ST_F2;
        end
        ST_F2: begin
          k_r <= m_fin;
          if (m_fin >= HAW'(3)) begin
            kk_r    <= HAW'(1);
            best_r  <= '1;
            state_r <= ST_C_KCHK;
          end else begin
            best_r  <= '0;
            root_r  <= '0;
            state_r <= ST_OUT;
          end
        end
        // rotating calipers: first antipode of vertex 0
        ST_C_KCHK: begin
          if ((kk_r + HAW'(1)) < k_r) begin
            state_r <= ST_C_K1;
          end else begin
            ci_r    <= '0;
            cj_r    <= kk_r;
            state_r <= ST_C_ICHK;
          end
        end
        ST_C_K1: begin
          pa_r    <= h_rdata;
          state_r <= ST_C_K2;
        end
        ST_C_K2: begin
          pb_r    <= h_rdata;
          c1_r    <= kk_r + HAW'(1);
          c2_r    <= kk_r;
          aret_r  <= ST_C_K3;
          state_r <= ST_AR1;
        end
        ST_C_K3: begin
          if (gt_r) begin
            kk_r    <= kk_r + HAW'(1);
            state_r <= ST_C_KCHK;
          end else begin
            ci_r    <= '0;
            cj_r    <= kk_r;
            state_r <= ST_C_ICHK;
          end
        end
        // main walk
        ST_C_ICHK: begin
          if (ci_r <= kk_r && cj_r < k_r) begin
            state_r <= ST_C_D1;
          end else begin
            rad_r   <= {best_r[RAD_W-7:0], 6'b0};
            rem_r   <= '0;
            root_r  <= '0;
            sqc_r   <= SQC_W'(HALF_W);
            state_r <= ST_SQ;
          end
        end
        ST_C_D1: begin
          pa_r    <= h_rdata;
          state_r <= ST_C_D2;
        end
        ST_C_D2: begin
          pc_r    <= h_rdata;
          dist_r  <= 1'b1;
          xret_r  <= ST_C_W0;
          state_r <= ST_X0;
        end
        ST_C_W0: state_r <= ST_C_W1;
        ST_C_W1: begin
          pb_r    <= h_rdata;
          state_r <= ST_C_WCHK;
        end
        ST_C_WCHK: begin
          if (cj_r < k_r) begin
            c1_r    <= c_jn;
            c2_r    <= cj_r;
            aret_r  <= ST_C_W2;
            state_r <= ST_AR1;
          end else begin
            ci_r    <= ci_r + HAW'(1);
            state_r <= ST_C_ICHK;
          end
        end
        ST_C_W2: begin
          if (gt_r) begin
            state_r <= ST_C_W3;
          end else begin
            ci_r    <= ci_r + HAW'(1);
            state_r <= ST_C_ICHK;
          end
        end
        ST_C_W3: begin
          pc_r    <= h_rdata;
          dist_r  <= 1'b1;
          xret_r  <= ST_C_W4;
          state_r <= ST_X0;
        end
        ST_C_W4: begin
          cj_r    <= cj_r + HAW'(1);
          state_r <= ST_C_WCHK;
        end
        // area compare: |cross(pa,pb,h[c1])| > |cross(pa,pb,h[c2])|
        ST_AR1: state_r <= ST_AR2;
        ST_AR2: begin
          pc_r    <= h_rdata;
          dist_r  <= 1'b0;
          xret_r  <= ST_AR3;
          state_r <= ST_X0;
        end
        ST_AR3: begin
          a1_r    <= cr_abs;
          state_r <= ST_AR4;
        end
        ST_AR4: begin
          pc_r    <= h_rdata;
          dist_r  <= 1'b0;
          xret_r  <= ST_AR5;
          state_r <= ST_X0;
        end
        ST_AR5: begin
          gt_r    <= (a1_r > cr_abs);
          state_r <= aret_r;
        end
        // arithmetic: cross product or squared distance over two products
        ST_X0: begin
          if (dist_r) begin
            op_a_r <= diff17(pa_r.x, pc_r.x);
            op_b_r <= diff17(pa_r.x, pc_r.x);
            t_a_r  <= diff17(pa_r.y, pc_r.y);
            t_b_r  <= diff17(pa_r.y, pc_r.y);
          end else begin
            op_a_r <= diff17(pb_r.x, pa_r.x);
            op_b_r <= diff17(pc_r.y, pa_r.y);
            t_a_r  <= diff17(pb_r.y, pa_r.y);
            t_b_r  <= diff17(pc_r.x, pa_r.x);
          end
          state_r <= ST_X1;
        end
        ST_X1: begin
          op_a_r  <= t_a_r;
          op_b_r  <= t_b_r;
          state_r <= ST_X2;
        end
        ST_X2: begin
          acc_r   <= prod_r;
          state_r <= ST_X3;
        end
        ST_X3: begin
          if (dist_r) begin
            if ({1'b0, dsum} < best_r) begin
              best_r <= SQ_W'(dsum);
            end
          end else begin
            cr_r <= $signed({acc_r[PROD_W-1], acc_r}) - $signed({prod_r[PROD_W-1], prod_r});
          end
          state_r <= xret_r;
        end
        // square root, one result bit per cycle
        ST_SQ: begin
          if (sqc_r == '0) begin
            state_r <= ST_OUT;
          end else begin
            rad_r <= {rad_r[RAD_W-3:0], 2'b00};
            sqc_r <= sqc_r - SQC_W'(1);
            if (rem_sh >= trial) begin
              rem_r  <= rem_sh - trial;
              root_r <= {root_r[HALF_W-2:0], 1'b1};
            end else begin
              rem_r  <= rem_sh;
              root_r <= {root_r[HALF_W-2:0], 1'b0};
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_tdata_r  <= {HSIZE_W'(k_r), root_r, best_r};
            cnt_r        <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/hmad_ram.sv */
// ----------------------------------------------------------------------------
// hmad_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hmad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
